// ===== src/mfca_pkg.sv =====
// Shared types and constants of the frame calibrator and averager.
package mfca_pkg;

  localparam int CHANNELS_DEF = 12;

  localparam logic [1:0] OP_DATA   = 2'd0;
  localparam logic [1:0] OP_GAIN   = 2'd1;
  localparam logic [1:0] OP_OFFSET = 2'd2;
  localparam logic [1:0] OP_EOB    = 2'd3;

  localparam logic [15:0] SYNC_WORD    = 16'hFEFE;
  localparam logic [15:0] SAMPLE_BIAS  = 16'h8000;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [16:0] HEADER_BYTES = 17'd52;

  localparam logic       CFG_MODE  = 1'b0;
  localparam logic       CFG_BYTES = 1'b1;
  localparam logic [1:0] MODE_AVG  = 2'd0;
  localparam logic [1:0] MODE_CAL  = 2'd1;

  typedef struct packed {
    logic accept;
    logic mul;
    logic acc;
    logic div_load;
    logic div_step;
    logic div_emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic mode_zero;
    logic out_busy;
    logic div_last;
    logic avg_last;
  } sts_t;

endpackage

// ===== src/multichannel_frame_calibrate_average.sv =====
// Top level of the multichannel frame calibrator and averager.
// A data word or a coefficient load is taken while the controller is idle; a data
// word that becomes a frame sample is captured, multiplied and then accumulated,
// plus any wait for the result register to drain. An end-of-block item in average
// mode runs the shared restoring divider for each channel in turn (load, 64
// quotient bits, emit); in the per-sample modes it clears the frame state and
// the sums. Input is stalled while an item is at work.
module multichannel_frame_calibrate_average #(
  parameter int CHANNELS = mfca_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_channel,
  input  logic [15:0]        in_word,
  input  logic signed [31:0] in_coefficient,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_channel,
  output logic signed [47:0] out_value,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data
);

  mfca_pkg::cmd_t cmd;
  mfca_pkg::sts_t sts;

  mfca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfca_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_channel     (in_channel),
    .in_word        (in_word),
    .in_coefficient (in_coefficient),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_channel    (out_channel),
    .out_value      (out_value),
    .out_last       (out_last)
  );

endmodule

// ===== src/mfca_ctrl.sv =====
// Controller state machine of the frame calibrator and averager.
module mfca_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_opcode,
  output logic             in_stall,
  input  mfca_pkg::sts_t   sts,
  output mfca_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DSTEP = 3'd4;
  localparam logic [2:0] S_DEMIT = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_opcode == mfca_pkg::OP_DATA) begin
            if (sts.take) state_nxt = S_MUL;
          end else if (in_opcode == mfca_pkg::OP_EOB) begin
            if (sts.mode_zero) state_nxt = S_DLOAD;
            else cmd.clear = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (sts.mode_zero || !sts.out_busy) begin
          cmd.acc   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DEMIT;
      end
      S_DEMIT: begin
        if (!sts.out_busy) begin
          cmd.div_emit = 1'b1;
          if (sts.avg_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DLOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== src/mfca_dp.sv =====
// Datapath: frame tracking, tables, calibration, sums and the average divider.
module mfca_dp #(
  parameter int CHANNELS = mfca_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mfca_pkg::cmd_t     cmd,
  output mfca_pkg::sts_t     sts,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_channel,
  input  logic [15:0]        in_word,
  input  logic signed [31:0] in_coefficient,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [3:0]         out_channel,
  output logic signed [47:0] out_value,
  output logic               out_last
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W:0] CH_NUM = (IDX_W + 1)'(CHANNELS);
  localparam logic [IDX_W-1:0] CH_LAST = IDX_W'(CHANNELS - 1);

  logic [1:0]  mode_r;
  logic [16:0] bytes_r;

  logic             sync_r, sync_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             skip_r, skip_nxt;
  logic [15:0]      pos_r, pos_nxt;

  logic signed [15:0] prior_r [CHANNELS];
  logic signed [63:0] sum_r   [CHANNELS];
  logic [15:0]        count_r [CHANNELS];
  logic signed [31:0] gain_r  [CHANNELS];
  logic signed [31:0] offs_r  [CHANNELS];

  logic               take;
  logic [IDX_W-1:0]   take_ch;
  logic [IDX_W:0]     idx_inc;
  logic [16:0]        limit;
  logic [15:0]        swapped;
  logic               ch_ok;

  logic [IDX_W-1:0]   ch_r;
  logic signed [15:0] s_r;
  logic signed [47:0] prod_r;
  logic signed [63:0] cal;

  logic [63:0]      q_r;
  logic [15:0]      rem_r;
  logic [15:0]      dvs_r;
  logic             neg_r;
  logic             dz_r;
  logic [5:0]       dcnt_r;
  logic [IDX_W-1:0] avg_ch_r;
  logic [16:0]      trial;
  logic [63:0]      qsigned;

  logic               out_valid_r;
  logic [3:0]         out_ch_r;
  logic signed [47:0] out_val_r;
  logic               out_last_r;
  logic               out_load;

  assign limit   = (bytes_r > mfca_pkg::HEADER_BYTES) ?
                   ((bytes_r - mfca_pkg::HEADER_BYTES) >> 1) : 17'd0;
  assign swapped = {in_word[7:0], in_word[15:8]};
  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign ch_ok   = ({1'b0, in_channel} < 5'(CHANNELS));

  // Frame tracking for one data word.
  always_comb begin
    sync_nxt     = sync_r;
    in_frame_nxt = in_frame_r;
    idx_nxt      = idx_r;
    skip_nxt     = skip_r;
    pos_nxt      = (pos_r != 16'hFFFF) ? pos_r + 16'd1 : pos_r;
    take         = 1'b0;
    take_ch      = '0;
    if (in_opcode == mfca_pkg::OP_DATA) begin
      if (in_frame_r) begin
        take    = 1'b1;
        take_ch = idx_r;
        if (idx_inc >= CH_NUM) begin
          in_frame_nxt = 1'b0;
          idx_nxt      = '0;
          skip_nxt     = 1'b1;
          sync_nxt     = 1'b0;
        end else begin
          idx_nxt = idx_inc[IDX_W-1:0];
        end
      end else if (skip_r) begin
        skip_nxt = 1'b0;
      end else if (pos_r < 16'd2 || {1'b0, pos_r} >= limit) begin
        sync_nxt = sync_r;
      end else if (in_word == mfca_pkg::SYNC_WORD) begin
        sync_nxt = 1'b1;
      end else if (sync_r) begin
        take = 1'b1;
        if (CHANNELS <= 1) begin
          skip_nxt = 1'b1;
          sync_nxt = 1'b0;
        end else begin
          in_frame_nxt = 1'b1;
          idx_nxt      = IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= mfca_pkg::MODE_AVG;
      bytes_r <= 17'd1024;
    end else if (cfg_we) begin
      if (cfg_index == mfca_pkg::CFG_MODE) mode_r <= cfg_data[1:0];
      else bytes_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sync_r     <= 1'b0;
      in_frame_r <= 1'b0;
      idx_r      <= '0;
      skip_r     <= 1'b0;
      pos_r      <= '0;
    end else if (cmd.accept && in_opcode == mfca_pkg::OP_DATA) begin
      sync_r     <= sync_nxt;
      in_frame_r <= in_frame_nxt;
      idx_r      <= idx_nxt;
      skip_r     <= skip_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prior_r[i] <= '0;
        gain_r[i]  <= '0;
        offs_r[i]  <= '0;
      end
    end else if (cmd.accept) begin
      if (in_opcode == mfca_pkg::OP_GAIN && ch_ok)
        gain_r[in_channel[IDX_W-1:0]] <= in_coefficient;
      if (in_opcode == mfca_pkg::OP_OFFSET && ch_ok)
        offs_r[in_channel[IDX_W-1:0]] <= in_coefficient;
      if (take && in_word != mfca_pkg::SYNC_WORD)
        prior_r[take_ch] <= swapped ^ mfca_pkg::SAMPLE_BIAS;
    end
  end

  // Sample capture and multiply; the accumulate follows in the ACC state.
  always_ff @(posedge clk) begin
    if (cmd.accept && take) begin
      ch_r <= take_ch;
      s_r  <= (in_word == mfca_pkg::SYNC_WORD) ? prior_r[take_ch]
                                               : (swapped ^ mfca_pkg::SAMPLE_BIAS);
    end
    if (cmd.mul) prod_r <= gain_r[ch_r] * s_r;
  end

  assign cal = 64'(prod_r) - 64'(offs_r[ch_r]);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]   <= '0;
        count_r[i] <= '0;
      end
    end else if (cmd.acc && count_r[ch_r] != mfca_pkg::COUNT_MAX) begin
      sum_r[ch_r]   <= sum_r[ch_r] + cal;
      count_r[ch_r] <= count_r[ch_r] + 16'd1;
    end
  end

  // Restoring divider on the magnitude of the sum, one quotient bit a cycle.
  assign trial   = {rem_r, q_r[63]};
  assign qsigned = neg_r ? (64'd0 - q_r) : q_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r  <= sum_r[avg_ch_r][63];
      q_r    <= sum_r[avg_ch_r][63] ? (64'd0 - 64'(sum_r[avg_ch_r]))
                                    : 64'(sum_r[avg_ch_r]);
      rem_r  <= '0;
      dvs_r  <= count_r[avg_ch_r];
      dz_r   <= (count_r[avg_ch_r] == 16'd0);
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= 16'(trial - {1'b0, dvs_r});
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= trial[15:0];
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.div_load) dcnt_r <= '0;
    else if (cmd.div_step) dcnt_r <= dcnt_r + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) avg_ch_r <= '0;
    else if (cmd.div_emit) avg_ch_r <= avg_ch_r + 1'b1;
  end

  assign out_load = (cmd.acc && mode_r != mfca_pkg::MODE_AVG) || cmd.div_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_emit) begin
      out_ch_r   <= 4'(avg_ch_r);
      out_val_r  <= dz_r ? 48'sd0 : qsigned[47:0];
      out_last_r <= (avg_ch_r == CH_LAST);
    end else if (out_load) begin
      out_ch_r   <= 4'(ch_r);
      out_val_r  <= (mode_r == mfca_pkg::MODE_CAL) ? cal[47:0] : 48'(s_r);
      out_last_r <= (ch_r == CH_LAST);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_value   = out_val_r;
  assign out_last    = out_last_r;

  assign sts.take      = take;
  assign sts.mode_zero = (mode_r == mfca_pkg::MODE_AVG);
  assign sts.out_busy  = out_valid_r && out_stall;
  assign sts.div_last  = (dcnt_r == 6'd63);
  assign sts.avg_last  = (avg_ch_r == CH_LAST);

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> ({1'b0, idx_r} < CH_NUM))
    else $error("frame index out of range");
  a_frame_skip: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_frame_r && skip_r))
    else $error("skip pending inside a frame");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_load && out_valid_r && out_stall))
    else $error("result register overwritten before transfer");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_emit |-> !$past(cmd.div_load))
    else $error("average emitted before division ran");

endmodule
